// ===== rtl/core/bsfb_pkg.sv =====
// Shared types, constants and helper functions for the byte-stuffed frame builder.
// Used by every module under rtl/core; depends on nothing else.
package bsfb_pkg;

    localparam int ByteW   = 8;
    localparam int MaxOut  = 6;
    localparam int CntW    = $clog2(MaxOut + 1);
    localparam int CfgIdxW = 3;

    typedef logic [ByteW-1:0]   byte_t;
    typedef logic [CntW-1:0]    cnt_t;
    typedef logic [CfgIdxW-1:0] cfg_idx_t;

    // Register indexes of the configuration port.
    localparam cfg_idx_t RegFlag      = 3'd0;
    localparam cfg_idx_t RegAddress   = 3'd1;
    localparam cfg_idx_t RegEscape    = 3'd2;
    localparam cfg_idx_t RegFlagSub   = 3'd3;
    localparam cfg_idx_t RegEscapeSub = 3'd4;

    localparam byte_t FlagReset      = 8'd126;
    localparam byte_t AddressReset   = 8'd3;
    localparam byte_t EscapeReset    = 8'd125;
    localparam byte_t FlagSubReset   = 8'd94;
    localparam byte_t EscapeSubReset = 8'd93;

    typedef struct packed {
        byte_t payload_byte;
        byte_t ctrl_value;
        logic  last_payload;
    } sfb_in_t;

    typedef struct packed {
        byte_t line_byte;
        logic  frame_end;
    } sfb_out_t;

    typedef struct packed {
        byte_t flag_value;
        byte_t address_value;
        byte_t escape_value;
        byte_t flag_substitute;
        byte_t escape_substitute;
    } sfb_cfg_t;

    // All line bytes caused by one item, first byte in slot 0.
    typedef struct packed {
        logic [MaxOut-1:0][ByteW-1:0] bytes;
        cnt_t                         count;
        logic                         close;
    } sfb_burst_t;

    // Status of the output queue as seen by the input side.
    typedef struct packed {
        logic empty;
        logic final_taken;
    } sfb_q_status_t;

    typedef struct packed {
        logic  two;
        byte_t b0;
        byte_t b1;
    } sfb_stuffed_t;

    // The flag comparison wins when flag and escape are equal.
    function automatic sfb_stuffed_t stuff_byte(input byte_t b, input sfb_cfg_t cfg);
        sfb_stuffed_t s;
        s.two = 1'b0;
        s.b0  = b;
        s.b1  = cfg.escape_substitute;
        if (b == cfg.flag_value)
        begin
            s.two = 1'b1;
            s.b0  = cfg.escape_value;
            s.b1  = cfg.flag_substitute;
        end
        else if (b == cfg.escape_value)
        begin
            s.two = 1'b1;
            s.b0  = cfg.escape_value;
            s.b1  = cfg.escape_substitute;
        end
        return s;
    endfunction

endpackage

// ===== rtl/core/bsfb_encoder.sv =====
// Frame state and per-item byte list generation for the frame builder.
// Depends on bsfb_pkg.
module bsfb_encoder
    import bsfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  sfb_in_t    item,
    input  sfb_cfg_t   cfg,
    output sfb_burst_t burst
);

    logic  inside_frame_reg;
    logic  inside_frame_next;
    byte_t check_accum_reg;
    byte_t check_accum_next;

    always_comb
    begin
        sfb_stuffed_t sd;
        sfb_stuffed_t sc;
        cnt_t         pos;
        byte_t        check_new;

        check_new = check_accum_reg ^ item.payload_byte;
        sd        = stuff_byte(item.payload_byte, cfg);
        sc        = stuff_byte(check_new, cfg);

        burst.bytes = '0;
        burst.close = 1'b0;
        pos         = '0;

        if (!inside_frame_reg)
        begin
            burst.bytes[0] = cfg.flag_value;
            burst.bytes[1] = cfg.address_value;
            burst.bytes[2] = item.ctrl_value;
            burst.bytes[3] = item.ctrl_value ^ cfg.address_value;
            pos            = cnt_t'(4);
        end

        burst.bytes[pos] = sd.b0;
        pos              = pos + cnt_t'(1);
        if (sd.two)
        begin
            burst.bytes[pos] = sd.b1;
            pos              = pos + cnt_t'(1);
        end

        // A last mark on the opening byte is ignored; the frame stays open.
        if (inside_frame_reg && item.last_payload)
        begin
            burst.bytes[pos] = sc.b0;
            pos              = pos + cnt_t'(1);
            if (sc.two)
            begin
                burst.bytes[pos] = sc.b1;
                pos              = pos + cnt_t'(1);
            end
            burst.bytes[pos] = cfg.flag_value;
            pos              = pos + cnt_t'(1);
            burst.close      = 1'b1;
        end
        burst.count = pos;

        inside_frame_next = inside_frame_reg;
        check_accum_next  = check_accum_reg;
        if (accept)
        begin
            if (!inside_frame_reg)
            begin
                inside_frame_next = 1'b1;
                check_accum_next  = item.payload_byte;
            end
            else if (item.last_payload)
            begin
                inside_frame_next = 1'b0;
                check_accum_next  = '0;
            end
            else
            begin
                check_accum_next = check_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_frame_reg <= 1'b0;
            check_accum_reg  <= '0;
        end
        else
        begin
            inside_frame_reg <= inside_frame_next;
            check_accum_reg  <= check_accum_next;
        end
    end

endmodule

// ===== rtl/core/bsfb_out_queue.sv =====
// Output shift register that holds one item's line bytes and sends one per cycle while the line does not stall.
// Depends on bsfb_pkg.
module bsfb_out_queue
    import bsfb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  sfb_burst_t    burst,
    output logic          line_valid,
    input  logic          line_stall,
    output sfb_out_t      line,
    output sfb_q_status_t status
);

    logic [MaxOut-1:0][ByteW-1:0] slots_reg;
    logic [MaxOut-1:0][ByteW-1:0] slots_next;
    cnt_t                         cnt_reg;
    cnt_t                         cnt_next;
    logic                         close_reg;
    logic                         close_next;
    logic                         take;

    assign line_valid         = (cnt_reg != '0);
    assign take               = line_valid && !line_stall;
    assign line.line_byte     = slots_reg[0];
    assign line.frame_end     = close_reg && (cnt_reg == cnt_t'(1));
    assign status.empty       = !line_valid;
    assign status.final_taken = take && (cnt_reg == cnt_t'(1));

    always_comb
    begin
        slots_next = slots_reg;
        cnt_next   = cnt_reg;
        close_next = close_reg;
        if (load)
        begin
            slots_next = burst.bytes;
            cnt_next   = burst.count;
            close_next = burst.close;
        end
        else if (take)
        begin
            for (int i = 0; i < MaxOut - 1; i++)
            begin
                slots_next[i] = slots_reg[i+1];
            end
            cnt_next = cnt_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            close_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            close_reg <= close_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slots_reg <= slots_next;
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == '0) || (take && cnt_reg == cnt_t'(1)))
        else $error("queue loaded while bytes still pending");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cnt_t'(MaxOut))
        else $error("queue count beyond capacity");
    a_take_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        take && !load |=> cnt_reg == $past(cnt_reg) - cnt_t'(1))
        else $error("queue count did not step down after a byte left");
`endif

endmodule

// ===== rtl/core/byte_stuffed_frame_builder.sv =====
// Byte-stuffed frame builder, top level: config registers, encoder and output queue.
// The first line byte of an item is valid in the cycle after the item is accepted.
// An item causes 1 to 6 line bytes; the output queue drains one byte per cycle while the
// line does not stall, and takes the next item as its final byte leaves.
// Reset: registers return to their defaults, no frame is open, check byte is zero,
// and the output queue is empty.
module byte_stuffed_frame_builder
    import bsfb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_wen,
    input  cfg_idx_t cfg_index,
    input  byte_t    cfg_data,
    input  logic     data_valid,
    output logic     data_stall,
    input  sfb_in_t  data,
    output logic     line_valid,
    input  logic     line_stall,
    output sfb_out_t line
);

    // Configuration registers. The user must write them only while the block is idle; the block
    // does not enforce this, and the encoder uses them directly at accept time.
    sfb_cfg_t cfg_reg;
    sfb_cfg_t cfg_next;

    sfb_burst_t    burst;
    sfb_q_status_t q_status;
    logic          accept;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                RegFlag:      cfg_next.flag_value        = cfg_data;
                RegAddress:   cfg_next.address_value     = cfg_data;
                RegEscape:    cfg_next.escape_value      = cfg_data;
                RegFlagSub:   cfg_next.flag_substitute   = cfg_data;
                RegEscapeSub: cfg_next.escape_substitute = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_value        <= FlagReset;
            cfg_reg.address_value     <= AddressReset;
            cfg_reg.escape_value      <= EscapeReset;
            cfg_reg.flag_substitute   <= FlagSubReset;
            cfg_reg.escape_substitute <= EscapeSubReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // An item is taken when the queue is empty, or when its final byte leaves
    // in this same cycle, so single-byte items stream at one per cycle while the line does not stall.
    assign data_stall = !(q_status.empty || q_status.final_taken);
    assign accept     = data_valid && !data_stall;

    bsfb_encoder u_encoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (data),
        .cfg    (cfg_reg),
        .burst  (burst)
    );

    bsfb_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .burst      (burst),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .line       (line),
        .status     (q_status)
    );

endmodule

// ===== tb/sv/tb_byte_stuffed_frame_builder.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the byte-stuffed frame builder: directed framing cases, then random
// frames under several idle and stall mixes. Depends only on bsfb_pkg and the block's top level.
module tb_byte_stuffed_frame_builder;
    import bsfb_pkg::*;

    // Clock and reset. The period is 2 ns; reset is held low at the start and then released.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    // Block inputs start at known values so nothing floats before reset ends.
    logic     cfg_wen = 1'b0;
    cfg_idx_t cfg_index = RegFlag;
    byte_t    cfg_data = '0;
    logic     data_valid = 1'b0;
    sfb_in_t  data = '0;
    logic     line_stall = 1'b0;
    logic     data_stall;
    logic     line_valid;
    sfb_out_t line;

    byte_stuffed_frame_builder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data       (data),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .line       (line)
    );

    // Percentages of cycles in which the sender holds back an item and the receiver stalls.
    int unsigned sender_idle_pct = 0;
    int unsigned line_stall_pct = 0;
    int unsigned error_count = 0;

    // The framer as the testbench understands it: its registers, whether a frame is open, and
    // the running XOR of the open frame's payload.
    sfb_cfg_t framer_cfg = '{
        flag_value:        FlagReset,
        address_value:     AddressReset,
        escape_value:      EscapeReset,
        flag_substitute:   FlagSubReset,
        escape_substitute: EscapeSubReset
    };
    logic     frame_open = 1'b0;
    byte_t    frame_check = '0;

    // Line bytes that accepted items have caused and that the block has not yet delivered.
    sfb_out_t pending_line[$];

    task automatic push_line(input byte_t b, input logic is_end);
        sfb_out_t o;
        o.line_byte = b;
        o.frame_end = is_end;
        pending_line.push_back(o);
    endtask

    // Payload and check bytes are stuffed. The flag comparison is made first, so when flag and
    // escape hold the same value the byte goes out as escape then flag substitute.
    task automatic push_stuffed(input byte_t b);
        if (b == framer_cfg.flag_value)
        begin
            push_line(framer_cfg.escape_value, 1'b0);
            push_line(framer_cfg.flag_substitute, 1'b0);
        end
        else if (b == framer_cfg.escape_value)
        begin
            push_line(framer_cfg.escape_value, 1'b0);
            push_line(framer_cfg.escape_substitute, 1'b0);
        end
        else
        begin
            push_line(b, 1'b0);
        end
    endtask

    // Work out the line bytes of one accepted item. The first byte of a frame gets the plain
    // header and never closes the frame, even when it carries the last mark.
    task automatic frame_line_bytes(input sfb_in_t it);
        if (!frame_open)
        begin
            push_line(framer_cfg.flag_value, 1'b0);
            push_line(framer_cfg.address_value, 1'b0);
            push_line(it.ctrl_value, 1'b0);
            push_line(it.ctrl_value ^ framer_cfg.address_value, 1'b0);
            push_stuffed(it.payload_byte);
            frame_check = it.payload_byte;
            frame_open = 1'b1;
        end
        else
        begin
            push_stuffed(it.payload_byte);
            frame_check = frame_check ^ it.payload_byte;
            if (it.last_payload)
            begin
                push_stuffed(frame_check);
                push_line(framer_cfg.flag_value, 1'b1);
                frame_open = 1'b0;
                frame_check = '0;
            end
        end
    endtask

    // The receiver stalls at random; the percentage changes from phase to phase.
    always @(posedge clk)
    begin
        line_stall <= ($urandom_range(99) < line_stall_pct);
    end

    // Every byte taken from the line is compared with the oldest expected byte.
    always @(posedge clk)
    begin : line_checker
        sfb_out_t want;
        if (rst_n && line_valid && !line_stall)
        begin
            if (pending_line.size() == 0)
            begin
                $display("%0t: unexpected line byte %02h end %0b", $time,
                         line.line_byte, line.frame_end);
                error_count++;
            end
            else
            begin
                want = pending_line.pop_front();
                if (line.line_byte !== want.line_byte)
                begin
                    $display("%0t: line_byte expected %02h actual %02h", $time,
                             want.line_byte, line.line_byte);
                    error_count++;
                end
                if (line.frame_end !== want.frame_end)
                begin
                    $display("%0t: frame_end expected %0b actual %0b", $time,
                             want.frame_end, line.frame_end);
                    error_count++;
                end
            end
        end
    end

    // Offer one item, hold it until the block takes it, then predict its bytes. Valid is only
    // lowered when a gap is chosen, so back-to-back items keep it high.
    task automatic send_item(input byte_t payload, input byte_t ctrl, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            data_valid <= 1'b0;
            data <= '{payload_byte: byte_t'($urandom), ctrl_value: byte_t'($urandom),
                      last_payload: 1'($urandom)};
            @(posedge clk);
        end
        data <= '{payload_byte: payload, ctrl_value: ctrl, last_payload: last};
        data_valid <= 1'b1;
        do
            @(posedge clk);
        while (data_stall);
        frame_line_bytes('{payload_byte: payload, ctrl_value: ctrl, last_payload: last});
    endtask

    // Stop sending and wait until every expected byte has come out.
    task automatic wait_line_idle();
        data_valid <= 1'b0;
        @(posedge clk);
        while (pending_line.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write. Indexes past the last register are ignored by the block.
    task automatic write_reg(input cfg_idx_t idx, input byte_t value);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            RegFlag:      framer_cfg.flag_value = value;
            RegAddress:   framer_cfg.address_value = value;
            RegEscape:    framer_cfg.escape_value = value;
            RegFlagSub:   framer_cfg.flag_substitute = value;
            RegEscapeSub: framer_cfg.escape_substitute = value;
            default:      ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all_regs(input byte_t flag, input byte_t addr, input byte_t esc,
                                  input byte_t flag_sub, input byte_t esc_sub);
        write_reg(RegFlag, flag);
        write_reg(RegAddress, addr);
        write_reg(RegEscape, esc);
        write_reg(RegFlagSub, flag_sub);
        write_reg(RegEscapeSub, esc_sub);
    endtask

    // Framing with the reset settings: flag and escape in the payload, a check byte that
    // equals the flag and one that equals the escape, and a last mark on a frame's first byte,
    // which must be ignored so the frame stays open.
    task automatic test_default_framing();
        send_item(8'h00, 8'hFF, 1'b1);
        send_item(FlagReset, 8'h00, 1'b0);
        send_item(EscapeReset, 8'h00, 1'b0);
        send_item(8'hFF, 8'h00, 1'b1);
        send_item(8'h10, 8'h5A, 1'b0);
        send_item(8'h10 ^ FlagReset, 8'h00, 1'b1);
        send_item(8'h20, 8'hA5, 1'b0);
        send_item(8'h20 ^ EscapeReset, 8'h00, 1'b1);
        wait_line_idle();
    endtask

    // Header bytes go out as they are, even when they equal the flag or the escape.
    task automatic test_header_unstuffed();
        write_reg(RegAddress, EscapeReset);
        send_item(8'h33, FlagReset, 1'b0);
        send_item(8'h44, 8'h00, 1'b1);
        wait_line_idle();
        write_reg(RegAddress, FlagReset);
        send_item(8'h55, 8'h00, 1'b0);
        send_item(8'h66, EscapeReset, 1'b1);
        wait_line_idle();
    endtask

    // With flag and escape set to the same value, the flag substitute is used.
    task automatic test_flag_equals_escape();
        write_all_regs(8'h55, 8'h01, 8'h55, 8'hAA, 8'hCC);
        send_item(8'h55, 8'h12, 1'b0);
        send_item(8'h55, 8'h00, 1'b0);
        send_item(8'h55, 8'h00, 1'b1);
        wait_line_idle();
    endtask

    // All registers at zero, then all at ones, and writes to the unused indexes in between.
    task automatic test_register_extremes();
        cfg_idx_t idx;
        write_all_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(8'h00, 8'h00, 1'b0);
        send_item(8'hFF, 8'hFF, 1'b1);
        wait_line_idle();
        for (int k = 1; k <= 3; k++)
        begin
            idx = cfg_idx_t'(RegEscapeSub + k);
            write_reg(idx, byte_t'($urandom));
        end
        write_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(8'hFF, 8'h00, 1'b0);
        send_item(8'h00, 8'hFF, 1'b1);
        wait_line_idle();
    endtask

    // The sender pauses inside a frame until the line is empty, the flag is changed, and the
    // frame then carries on under the new setting.
    task automatic test_pause_mid_frame();
        write_all_regs(FlagReset, AddressReset, EscapeReset, FlagSubReset, EscapeSubReset);
        send_item(8'h41, 8'h07, 1'b0);
        wait_line_idle();
        write_reg(RegFlag, 8'h41);
        send_item(8'h41, 8'h00, 1'b0);
        send_item(8'h99, 8'h00, 1'b1);
        wait_line_idle();
    endtask

    // Payload bytes lean toward the current flag and escape so that stuffing happens often.
    function automatic byte_t stuffing_prone_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
            return framer_cfg.flag_value;
        else if (r < 30)
            return framer_cfg.escape_value;
        else if (r < 35)
            return 8'h00;
        else if (r < 40)
            return 8'hFF;
        return byte_t'($urandom);
    endfunction

    // Random frames for one phase. Most frames are well formed; a few carry a last mark on the
    // first byte or random last marks throughout.
    task automatic test_random_frames(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned item_target);
        int unsigned sent;
        int unsigned len;
        int unsigned shape;
        logic        last;
        byte_t       flag;
        wait_line_idle();
        flag = byte_t'($urandom);
        if ($urandom_range(3) == 0)
            write_all_regs(flag, byte_t'($urandom), flag, byte_t'($urandom), byte_t'($urandom));
        else
            write_all_regs(flag, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                           byte_t'($urandom));
        sender_idle_pct = idle_pct;
        line_stall_pct = stall_pct;
        sent = 0;
        while (sent < item_target)
        begin
            len = $urandom_range(8, 2);
            shape = $urandom_range(9);
            for (int unsigned k = 0; k < len; k++)
            begin
                if (shape == 0)
                    last = 1'($urandom);
                else if (shape == 1 && k == 0)
                    last = 1'b1;
                else
                    last = (k == len - 1);
                send_item(stuffing_prone_byte(), byte_t'($urandom), last);
                sent++;
            end
        end
        wait_line_idle();
        sender_idle_pct = 0;
        line_stall_pct = 0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_framing();
        test_header_unstuffed();
        test_flag_equals_escape();
        test_register_extremes();
        test_pause_mid_frame();

        test_random_frames(0, 0, 125);
        test_random_frames(87, 0, 125);
        test_random_frames(0, 87, 125);
        test_random_frames(17, 17, 125);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Safety net against a hung handshake or bytes that never arrive.
    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
